// ===== hdl/b2b_pkg.sv =====
// Constants and helpers shared by the BLAKE2b hash core and its digest checker.
package b2b_pkg;

  localparam logic [63:0] IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  // message schedule, entry j of a row in bits 4j+3:4j
  localparam logic [63:0] SIGMA [10] = '{
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE,
    64'h491763EADF250C8B, 64'h8F04A562EBCD1397,
    64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD,
    64'h5A417D2C803B9EF6, 64'h0DC3E9BF5167482A
  };

  localparam logic [31:0] PARAM_BASE  = 32'h01010000;
  localparam logic [7:0]  BLOCK_BYTES = 8'd128;
  localparam logic [3:0]  LAST_ROUND  = 4'd11;
  localparam logic [3:0]  LAST_SIGMA  = 4'd9;
  localparam logic [3:0]  LAST_WORD   = 4'd15;

  // digest length with out-of-range codes folded to 1..64
  function automatic logic [6:0] clamp_len(input logic [6:0] n);
    logic [6:0] r;
    r = n;
    if (n == 7'd0) r = 7'd1;
    else if (n > 7'd64) r = 7'd64;
    return r;
  endfunction

  function automatic logic [63:0] chain0_init(input logic [6:0] n);
    return IV[0] ^ {32'd0, PARAM_BASE} ^ {57'd0, clamp_len(n)};
  endfunction

endpackage

// ===== hdl/blake2b_hash_top.sv =====
// BLAKE2b unkeyed hash core with one shared quarter-G unit.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_message_word, in_last_of_message,    | taken when start && !busy
//          | in_total_length                         |
//  result  | out_digest_word, out_valid_bytes,       | out_valid, one cycle each
//          | out_last_word                           |
//  config  | cfg_digest_bytes                        | cfg_we
//
// A word that does not close a block is just stored. A closing word adds a load
// state, 12 rounds x 8 G x 4 steps through the shared adder/rotator and a fold
// state; the last word then adds one digest word per cycle. Reset (rst_n low,
// synchronous) clears the state, position, byte counters, flags and message words
// and restores the chain. The receiver cannot stall: results leave as produced.
module blake2b_hash_top
  import b2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_message_word,
  input  logic        in_last_of_message,
  input  logic [63:0] in_total_length,
  output logic        out_valid,
  output logic [63:0] out_digest_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_word,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_digest_bytes
);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ROUND, S_FOLD, S_OUT} state_t;

  state_t      state_r;
  logic [6:0]  cfg_r;
  logic [63:0] chain_r [8];
  logic [63:0] mb_r [16];
  logic [63:0] v_r [4][4];
  logic [63:0] cnt0_r, cnt1_r, t0_r, t1_r;
  logic        final_r, msg_active_r;
  logic [3:0]  pos_r, round_r, sig_r;
  logic [1:0]  step_r, g_r;
  logic        diag_r;
  logic [2:0]  k_r;
  logic        out_valid_r, out_last_r;
  logic [63:0] out_word_r;
  logic [3:0]  out_vb_r;

  // shared quarter-G unit: even steps a+=b+m, d=rotr(d^a); odd c+=d, b=rotr(b^c)
  logic [3:0]  sel, midx;
  logic [63:0] op_p, op_q, op_m, sum, mixed, rot;
  logic [63:0] v_w   [4][4];
  logic [63:0] v_nxt [4][4];
  logic [1:0]  amt [4];

  always_comb begin
    sel  = {diag_r, g_r, step_r[1]};
    midx = SIGMA[sig_r][{sel, 2'b00} +: 4];
    op_p = step_r[0] ? v_r[2][0] : v_r[0][0];
    op_q = step_r[0] ? v_r[3][0] : v_r[1][0];
    op_m = step_r[0] ? 64'd0 : mb_r[midx];
    sum  = op_p + op_q + op_m;
    mixed = step_r[0] ? (v_r[1][0] ^ sum) : (v_r[3][0] ^ sum);
    case (step_r)
      2'd0:    rot = {mixed[31:0], mixed[63:32]};
      2'd1:    rot = {mixed[23:0], mixed[63:24]};
      2'd2:    rot = {mixed[15:0], mixed[63:16]};
      default: rot = {mixed[62:0], mixed[63]};
    endcase
    v_w = v_r;
    if (step_r[0]) begin
      v_w[2][0] = sum;
      v_w[1][0] = rot;
    end else begin
      v_w[0][0] = sum;
      v_w[3][0] = rot;
    end
    // after each G the rows shift by one word; at the end of a half-round
    // they also (un)diagonalize
    for (int r = 0; r < 4; r++) begin
      if (g_r == 2'd3)
        amt[r] = diag_r ? 2'd1 - 2'(r) : 2'd1 + 2'(r);
      else
        amt[r] = 2'd1;
    end
    for (int r = 0; r < 4; r++)
      for (int p = 0; p < 4; p++)
        v_nxt[r][p] = (step_r == 2'd3) ? v_w[r][2'(p) + amt[r]] : v_w[r][p];
  end

  // digest word selection
  logic [6:0] n_len, rem;
  logic [3:0] nwords, vb;
  logic [63:0] dmask;
  always_comb begin
    n_len  = clamp_len(cfg_r);
    nwords = 4'((n_len + 7'd7) >> 3);
    rem    = n_len - {1'b0, k_r, 3'b000};
    vb     = (rem >= 7'd8) ? 4'd8 : rem[3:0];
    for (int j = 0; j < 8; j++)
      dmask[8*j +: 8] = (4'(j) < vb) ? 8'hFF : 8'h00;
  end

  logic [63:0] cnt0_add;
  assign cnt0_add = cnt0_r + {56'd0, BLOCK_BYTES};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_r        <= 7'd64;
      for (int i = 0; i < 8; i++)
        chain_r[i] <= (i == 0) ? chain0_init(7'd64) : IV[i];
      for (int i = 0; i < 16; i++) mb_r[i] <= 64'd0;
      cnt0_r       <= 64'd0;
      cnt1_r       <= 64'd0;
      pos_r        <= 4'd0;
      msg_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      if (cfg_we) begin
        cfg_r <= cfg_digest_bytes;
        if (!msg_active_r) chain_r[0] <= chain0_init(cfg_digest_bytes);
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            msg_active_r <= 1'b1;
            mb_r[pos_r]  <= in_message_word;
            if (in_last_of_message) begin
              t0_r    <= in_total_length;
              t1_r    <= 64'd0;
              final_r <= 1'b1;
              state_r <= S_INIT;
            end else if (pos_r == LAST_WORD) begin
              cnt0_r  <= cnt0_add;
              cnt1_r  <= cnt1_r + {63'd0, cnt0_add < {56'd0, BLOCK_BYTES}};
              t0_r    <= cnt0_add;
              t1_r    <= cnt1_r + {63'd0, cnt0_add < {56'd0, BLOCK_BYTES}};
              final_r <= 1'b0;
              pos_r   <= 4'd0;
              state_r <= S_INIT;
            end else begin
              pos_r <= pos_r + 4'd1;
            end
          end
        end
        S_INIT: begin
          for (int p = 0; p < 4; p++) begin
            v_r[0][p] <= chain_r[p];
            v_r[1][p] <= chain_r[p+4];
            v_r[2][p] <= IV[p];
          end
          v_r[3][0] <= IV[4] ^ t0_r;
          v_r[3][1] <= IV[5] ^ t1_r;
          v_r[3][2] <= final_r ? ~IV[6] : IV[6];
          v_r[3][3] <= IV[7];
          step_r  <= 2'd0;
          g_r     <= 2'd0;
          diag_r  <= 1'b0;
          round_r <= 4'd0;
          sig_r   <= 4'd0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          v_r    <= v_nxt;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            g_r <= g_r + 2'd1;
            if (g_r == 2'd3) begin
              diag_r <= ~diag_r;
              if (diag_r) begin
                round_r <= round_r + 4'd1;
                sig_r   <= (sig_r == LAST_SIGMA) ? 4'd0 : sig_r + 4'd1;
                if (round_r == LAST_ROUND) state_r <= S_FOLD;
              end
            end
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++)
            chain_r[i] <= chain_r[i] ^ v_r[i/4][i%4] ^ v_r[2 + i/4][i%4];
          for (int i = 0; i < 16; i++) mb_r[i] <= 64'd0;
          k_r     <= 3'd0;
          state_r <= final_r ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_word_r  <= chain_r[k_r] & dmask;
          out_vb_r    <= vb;
          k_r         <= k_r + 3'd1;
          if ({1'b0, k_r} + 4'd1 == nwords) begin
            out_last_r <= 1'b1;
            for (int i = 0; i < 8; i++)
              chain_r[i] <= (i == 0) ? chain0_init(cfg_r) : IV[i];
            cnt0_r       <= 64'd0;
            cnt1_r       <= 64'd0;
            pos_r        <= 4'd0;
            msg_active_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_valid_bytes = out_vb_r;
  assign out_last_word   = out_last_r;

  a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word |-> out_valid)
    else $error("last flag without result");

  a_fold_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD) |-> ($past(state_r) == S_ROUND && $past(round_r) == LAST_ROUND))
    else $error("fold without full round set");

  a_results_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(final_r) && $past(state_r) == S_OUT |-> out_last_word)
    else $error("message ended without last digest word");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (round_r <= LAST_ROUND && sig_r <= LAST_SIGMA))
    else $error("round counter out of range");

endmodule

// ===== tb/sv/blake2b_digest_checker.sv =====
// Watches the hash core's channels, predicts each digest and compares the words, byte counts and last flags.
module blake2b_digest_checker
  import b2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_message_word,
  input  logic        in_last_of_message,
  input  logic [63:0] in_total_length,
  input  logic        out_valid,
  input  logic [63:0] out_digest_word,
  input  logic [3:0]  out_valid_bytes,
  input  logic        out_last_word,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_digest_bytes,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];

  logic [63:0] chain [8];
  logic [63:0] mblk [16];
  logic [63:0] wv [16];
  logic [63:0] cnt_lo, cnt_hi;
  logic [3:0]  wpos;
  logic [6:0]  dlen_reg;
  logic        in_msg;

  function automatic int eff_len();
    if (dlen_reg == 7'd0) return 1;
    if (dlen_reg > 7'd64) return 64;
    return int'(dlen_reg);
  endfunction

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic restart_chain();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    chain[0] ^= 64'h0000_0000_0101_0000 ^ 64'(eff_len());
  endtask

  task automatic gmix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
    wv[a] = wv[a] + wv[b] + x;
    wv[d] = rotr(wv[d] ^ wv[a], 32);
    wv[c] = wv[c] + wv[d];
    wv[b] = rotr(wv[b] ^ wv[c], 24);
    wv[a] = wv[a] + wv[b] + y;
    wv[d] = rotr(wv[d] ^ wv[a], 16);
    wv[c] = wv[c] + wv[d];
    wv[b] = rotr(wv[b] ^ wv[c], 63);
  endtask

  task automatic compress_block(logic [63:0] t0, logic [63:0] t1, bit fin);
    logic [63:0] s;
    for (int i = 0; i < 8; i++) begin
      wv[i] = chain[i];
      wv[i+8] = IV[i];
    end
    wv[12] ^= t0;
    wv[13] ^= t1;
    if (fin) wv[14] = ~wv[14];
    for (int r = 0; r < 12; r++) begin
      s = SIGMA[r % 10];
      gmix(0, 4, 8, 12, mblk[s[3:0]], mblk[s[7:4]]);
      gmix(1, 5, 9, 13, mblk[s[11:8]], mblk[s[15:12]]);
      gmix(2, 6, 10, 14, mblk[s[19:16]], mblk[s[23:20]]);
      gmix(3, 7, 11, 15, mblk[s[27:24]], mblk[s[31:28]]);
      gmix(0, 5, 10, 15, mblk[s[35:32]], mblk[s[39:36]]);
      gmix(1, 6, 11, 12, mblk[s[43:40]], mblk[s[47:44]]);
      gmix(2, 7, 8, 13, mblk[s[51:48]], mblk[s[55:52]]);
      gmix(3, 4, 9, 14, mblk[s[59:56]], mblk[s[63:60]]);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= wv[i] ^ wv[i+8];
    for (int i = 0; i < 16; i++) mblk[i] = '0;
  endtask

  task automatic absorb_word(logic [63:0] w, logic last, logic [63:0] total);
    int n, nw, vb;
    digest_word_t e;
    in_msg = 1'b1;
    mblk[wpos] = w;
    if (!last) begin
      if (wpos == 4'd15) begin
        cnt_lo += 64'd128;
        if (cnt_lo < 64'd128) cnt_hi += 64'd1;   // carry only on real wrap
        compress_block(cnt_lo, cnt_hi, 1'b0);
        wpos = '0;
      end else begin
        wpos++;
      end
      return;
    end
    compress_block(total, 64'd0, 1'b1);
    n = eff_len();
    nw = (n + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      vb = n - 8 * k;
      if (vb > 8) vb = 8;
      e.word = chain[k];
      if (vb < 8) e.word &= (64'd1 << (8 * vb)) - 64'd1;
      e.nbytes = 4'(vb);
      e.last = (k + 1 == nw);
      digest_q.push_back(e);
    end
    restart_chain();
    cnt_lo = '0;
    cnt_hi = '0;
    wpos = '0;
    in_msg = 1'b0;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    digest_word_t e;
    if (!rst_n) begin
      dlen_reg = 7'd64;
      restart_chain();
      for (int i = 0; i < 16; i++) mblk[i] = '0;
      cnt_lo = '0;
      cnt_hi = '0;
      wpos = '0;
      in_msg = 1'b0;
      digest_q.delete();
    end else begin
      if (out_valid) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h/%0d/%0d", $time,
                   out_digest_word, out_valid_bytes, out_last_word);
          fails++;
        end else begin
          e = digest_q.pop_front();
          if (out_digest_word !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word,
                     out_digest_word);
            fails++;
          end
          if (out_valid_bytes !== e.nbytes) begin
            $display("%0t: valid_bytes expected %0d actual %0d", $time, e.nbytes,
                     out_valid_bytes);
            fails++;
          end
          if (out_last_word !== e.last) begin
            $display("%0t: last_word expected %0d actual %0d", $time, e.last,
                     out_last_word);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        dlen_reg = cfg_digest_bytes;
        if (!in_msg) restart_chain();
      end
      if (start && !busy) absorb_word(in_message_word, in_last_of_message, in_total_length);
    end
    pending = digest_q.size();
  end
endmodule

// ===== tb/sv/tb_blake2b_hash_top.sv =====
// Stimulus and verdict for the BLAKE2b hash core.
module tb_blake2b_hash_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_message_word = '0;
  logic        in_last_of_message = 1'b0;
  logic [63:0] in_total_length = '0;
  logic        out_valid;
  logic [63:0] out_digest_word;
  logic [3:0]  out_valid_bytes;
  logic        out_last_word;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_digest_bytes = '0;
  int          fails, pending;
  int          idle_pct = 0;
  int          words_sent = 0;

  blake2b_hash_top DUT (.*);

  blake2b_digest_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic feed_word(logic [63:0] w, logic last, logic [63:0] total);
    start <= 1'b1;
    in_message_word <= w;
    in_last_of_message <= last;
    in_total_length <= total;
    do @(posedge clk); while (busy);
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // hold off until the core is quiet and every digest word is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_len(logic [6:0] v);
    cfg_we <= 1'b1;
    cfg_digest_bytes <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // nbytes 0 is the empty message; mid_len >= 0 rewrites the length mid-message
  task automatic hash_msg(int nbytes, bit bad_total, int mid_len);
    int nw, tail;
    logic [63:0] w;
    nw = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    tail = nbytes % 8;
    for (int i = 0; i < nw; i++) begin
      w = (nbytes == 0) ? 64'd0 : rand64();
      if (i == nw - 1 && tail != 0) w &= (64'd1 << (8 * tail)) - 64'd1;
      if (i == nw - 1)
        feed_word(w, 1'b1, bad_total ? rand64() : 64'(nbytes));
      else
        feed_word(w, 1'b0, rand64());
      if (i == 0 && nw > 1 && mid_len >= 0) begin
        drain();
        write_len(7'(mid_len));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, extremes of length and data, block boundaries
    hash_msg(0, 0, -1);
    feed_word('1, 1'b1, 64'd8);
    feed_word('1, 1'b1, '1);
    hash_msg(128, 0, -1);
    hash_msg(129, 0, -1);
    hash_msg(256, 0, -1);
    drain();
    write_len(7'd1);
    hash_msg(5, 0, -1);
    drain();
    write_len(7'd0);
    hash_msg(17, 0, -1);
    drain();
    write_len(7'd127);
    hash_msg(40, 0, -1);
    drain();
    write_len(7'd65);
    hash_msg(3, 1, -1);
    drain();
    write_len(7'd9);
    hash_msg(24, 0, 33);
    hash_msg(24, 0, -1);
    drain();
    write_len(7'd64);
    // random part in idle phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 72;
        2: idle_pct = 12;
        default: idle_pct = 0;
      endcase
      while (words_sent < 80 + 75 * (ph + 1)) begin
        if ($urandom_range(9) == 0) begin
          drain();
          write_len(7'($urandom_range(0, 127)));
        end
        hash_msg(($urandom_range(9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 140),
                 $urandom_range(9) == 0,
                 ($urandom_range(19) == 0) ? int'($urandom_range(1, 64)) : -1);
      end
    end
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/b2b_pkg.sv
hdl/blake2b_hash_top.sv
tb/sv/blake2b_digest_checker.sv
tb/sv/tb_blake2b_hash_top.sv
